FILE: rtl/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

    // Default ring size and byte width
    localparam int DEPTH_DEF = 16;
    localparam int BYTE_W    = 8;

    typedef logic [1:0] cmd_t;

    // Operation codes carried in s_tuser
    localparam cmd_t CMD_PUSH_FRONT = 2'd0;
    localparam cmd_t CMD_PUSH_BACK  = 2'd1;
    localparam cmd_t CMD_POP_FRONT  = 2'd2;
    localparam cmd_t CMD_POP_BACK   = 2'd3;

    // Per-operation status from the pointer unit
    typedef struct packed {
        logic wr_en;   // push that fits: write the byte
        logic pop_ok;  // pop on a non-empty deque
        logic err;     // push on full or pop on empty
    } op_t;

endpackage

`default_nettype wire

FILE: rtl/byte_deque_top.sv
// Bounded double-ended queue of bytes in a ring of DEPTH entries held in one
// RAM. Each input item is an operation (s_tuser: push front, push back, pop
// front, pop back; s_tdata: byte to push). Each item yields one result with
// the popped byte, the front and back bytes after the operation, the count
// and an error flag (pop on empty or push on full; such items change
// nothing). A new item is accepted only once the last result is loaded,
// and loading waits while the result side stalls: the single RAM read
// port is used for the popped byte, the new front and the new back in
// turn, then the result is loaded. A finished result waits in the output
// register while the next item is accepted. No clearing pass follows
// reset.
`default_nettype none

module byte_deque_top #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: value[7:0]
    input  wire logic [7:0]  s_tdata,
    // s_tuser: cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: popped[7:0], front_byte[15:8], back_byte[23:16], count, zero pad
    output logic [((3*bdq_pkg::BYTE_W+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // m_tuser: error[0]
    output logic [0:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    import bdq_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int TDATA_W = ((3*BYTE_W + CW + 7)/8)*8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FRONT = 3'd1;
    localparam logic [2:0] S_BACK  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic               s_acc;
    logic               out_free;
    op_t                op;
    logic [AW-1:0]      wr_addr, pop_addr, head, back_slot, rd_addr;
    logic [CW-1:0]      cnt;
    logic [BYTE_W-1:0]  rd_data;
    logic               pop_ok_reg, err_reg;
    logic [BYTE_W-1:0]  popped_reg, front_reg, back_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic [0:0]         m_tuser_reg;

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    bdq_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_en    (s_acc),
        .cmd      (s_tuser),
        .op       (op),
        .wr_addr  (wr_addr),
        .pop_addr (pop_addr),
        .head     (head),
        .back_slot(back_slot),
        .count    (cnt)
    );

    // Read address: popped entry first, then new front, then new back
    always_comb begin
        unique case (state_reg)
            S_IDLE:  rd_addr = pop_addr;
            S_FRONT: rd_addr = head;
            S_BACK:  rd_addr = back_slot;
            default: rd_addr = head;
        endcase
    end

    bdq_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (op.wr_en),
        .wr_addr(wr_addr),
        .wr_data(s_tdata),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Sequencer and output valid
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:  if (s_acc) state_next = S_FRONT;
            S_FRONT: state_next = S_BACK;
            S_BACK:  state_next = S_FIN;
            S_FIN:   state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Capture the read data and build the result item
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            pop_ok_reg <= op.pop_ok;
            err_reg    <= op.err;
        end
        if (state_reg == S_FRONT) begin
            popped_reg <= pop_ok_reg ? rd_data : '0;
        end
        if (state_reg == S_BACK) begin
            front_reg <= rd_data;
        end
        if (state_reg == S_FIN) begin
            back_reg <= rd_data;
        end
        if (state_reg == S_OUT && out_free) begin
            if (cnt == '0) begin
                m_tdata_reg <= TDATA_W'({cnt, {BYTE_W{1'b0}}, {BYTE_W{1'b0}}, popped_reg});
            end else begin
                m_tdata_reg <= TDATA_W'({cnt, back_reg, front_reg, popped_reg});
            end
            m_tuser_reg <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Count never passes the ring size
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt <= CW'(DEPTH))
        else $error("deque count above DEPTH");

    // A rejected operation leaves the count alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        op.err |=> $stable(cnt))
        else $error("count changed on error");

    // A successful push adds one entry, a successful pop removes one
    assert property (@(posedge aclk) disable iff (!aresetn)
        op.wr_en |=> (cnt == $past(cnt) + CW'(1)))
        else $error("push did not add one entry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        op.pop_ok |=> (cnt == $past(cnt) - CW'(1)))
        else $error("pop did not remove one entry");

    // A new result only comes out of the load state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg && !m_tready)) |-> ($past(state_reg) == S_OUT))
        else $error("result loaded outside load state");

endmodule

`default_nettype wire

FILE: rtl/bdq_ram.sv
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/bdq_ptr.sv
`default_nettype none

module bdq_ptr #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       op_en,
    input  wire bdq_pkg::cmd_t              cmd,
    output bdq_pkg::op_t                    op,
    output logic [$clog2(DEPTH)-1:0]        wr_addr,
    output logic [$clog2(DEPTH)-1:0]        pop_addr,
    output logic [$clog2(DEPTH)-1:0]        head,
    output logic [$clog2(DEPTH)-1:0]        back_slot,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          full, empty;
    logic [AW-1:0] head_m1, head_p1, tail_slot, last_slot;
    op_t           op_raw;

    // Ring position base + off, off below DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Slots derived from the current head and count
    assign head_m1   = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_p1   = ring_add(head_reg, AW'(1));
    assign tail_slot = ring_add(head_reg, count_reg[AW-1:0]);
    assign last_slot = ring_add(head_reg, AW'(count_reg - CW'(1)));

    // Decode the operation
    always_comb begin
        op_raw     = '0;
        wr_addr    = tail_slot;
        pop_addr   = head_reg;
        head_next  = head_reg;
        count_next = count_reg;
        unique case (cmd)
            CMD_PUSH_FRONT: begin
                wr_addr       = head_m1;
                op_raw.wr_en  = !full;
                op_raw.err    = full;
                if (!full) begin
                    head_next  = head_m1;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_PUSH_BACK: begin
                wr_addr       = tail_slot;
                op_raw.wr_en  = !full;
                op_raw.err    = full;
                if (!full) begin
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP_FRONT: begin
                pop_addr      = head_reg;
                op_raw.pop_ok = !empty;
                op_raw.err    = empty;
                if (!empty) begin
                    head_next  = head_p1;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_POP_BACK: begin
                pop_addr      = last_slot;
                op_raw.pop_ok = !empty;
                op_raw.err    = empty;
                if (!empty) begin
                    count_next = count_reg - CW'(1);
                end
            end
            default: ;
        endcase
    end

    assign op = op_en ? op_raw : '0;

    // Head and count update only on an accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (op_en) begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign head      = head_reg;
    assign back_slot = last_slot;
    assign count     = count_reg;

endmodule

`default_nettype wire
